// ===== src/ptwa_pkg.sv =====
package ptwa_pkg;

   localparam int TABLE_DEPTH = 8;
   localparam int IDX_W = 3;
   localparam int CNT_W = 4;

   typedef enum logic [1:0] {
      CMD_BEACON = 2'd0,
      CMD_SWEEP  = 2'd1,
      CMD_READ   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_EVICTED  = 3'd2,
      ST_WEAK     = 3'd3,
      ST_OWN      = 3'd4,
      ST_DONE     = 3'd5,
      ST_BAD      = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_SHIFT,
      FSM_WRITE,
      FSM_RESULT
   } fsm_type;

   localparam logic [1:0] REG_OWN_ID    = 2'd0;
   localparam logic [1:0] REG_FLOOR     = 2'd1;
   localparam logic [1:0] REG_TTL       = 2'd2;
   localparam logic [1:0] REG_THRESHOLD = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] now_time;
      logic [31:0] beacon_id;
      logic signed [7:0] signal;
      logic [15:0] capabilities;
      logic [7:0]  radio_slot;
      logic [2:0]  entry_index;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  position;
      logic        newly_qualified;
      logic signed [7:0] avg_signal;
      logic [31:0] entry_id;
      logic [15:0] entry_caps;
      logic [7:0]  entry_slot;
      logic [7:0]  entry_hits;
      logic        entry_qualified;
      logic [3:0]  occupancy;
      logic [3:0]  removed;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_step;
      logic shift_step;
      logic write;
      logic result;
   } ctl_type;

   typedef struct packed {
      logic        scan_last;
      logic        shift_last;
      logic        need_shift;
      logic        need_write;
   } sts_type;

   function automatic logic signed [7:0] quarter_to_dbm(input logic signed [10:0] q);
      logic signed [10:0] t;
      begin
         t = q + (q[10] ? 11'sd3 : 11'sd0);
         return t[9:2];
      end
   endfunction

endpackage

// ===== src/ptwa_datapath.sv =====
module ptwa_datapath (
   input  logic clock,
   input  logic reset,
   input  ptwa_pkg::ctl_type ctl,
   output ptwa_pkg::sts_type sts,
   input  ptwa_pkg::req_word_type req_word,
   input  logic [31:0] own_id,
   input  logic signed [7:0] signal_floor,
   input  logic [31:0] time_to_live,
   input  logic [7:0] hit_threshold,
   output ptwa_pkg::rsp_word_type rsp_word
);

   logic [31:0] ids_ff [ptwa_pkg::TABLE_DEPTH];
   logic [31:0] seen_ff [ptwa_pkg::TABLE_DEPTH];
   logic signed [10:0] avgq_ff [ptwa_pkg::TABLE_DEPTH];
   logic [15:0] caps_ff [ptwa_pkg::TABLE_DEPTH];
   logic [7:0] slot_ff [ptwa_pkg::TABLE_DEPTH];
   logic [7:0] hits_ff [ptwa_pkg::TABLE_DEPTH];
   logic qual_ff [ptwa_pkg::TABLE_DEPTH];

   ptwa_pkg::req_word_type req_ff;
   logic [ptwa_pkg::CNT_W-1:0] count_ff, count_in;
   logic [ptwa_pkg::IDX_W-1:0] scan_ff, scan_in;
   logic [ptwa_pkg::IDX_W-1:0] sh_ff, sh_in;
   logic [ptwa_pkg::IDX_W-1:0] pos_ff, pos_in;
   logic found_ff, found_in;
   logic [31:0] wage_ff, wage_in;
   logic [ptwa_pkg::IDX_W-1:0] worst_ff, worst_in;
   logic [ptwa_pkg::CNT_W-1:0] removed_ff, removed_in;
   logic [2:0] status_ff, status_in;
   logic nq_ff;
   ptwa_pkg::rsp_word_type rsp_ff, rsp_in;

   logic [31:0] age;
   logic expired;
   logic hit;
   logic signed [7:0] dbm_i, dbm_w;
   logic signed [10:0] sig4, diff, upd_q;
   logic signed [10:0] dq;
   logic [7:0] new_hits;
   logic new_qual;
   logic [ptwa_pkg::IDX_W-1:0] wpos;
   logic in_table;

   assign in_table = {1'b0, scan_ff} < count_ff;
   assign hit = in_table && ids_ff[scan_ff] == req_ff.beacon_id;
   assign age = req_ff.now_time - seen_ff[scan_ff];
   assign expired = age >= time_to_live;
   assign dbm_i = ptwa_pkg::quarter_to_dbm(avgq_ff[scan_ff]);
   assign dbm_w = ptwa_pkg::quarter_to_dbm(avgq_ff[worst_ff]);
   assign sig4 = {{1{req_ff.signal[7]}}, req_ff.signal, 2'b00};
   assign diff = sig4 - avgq_ff[pos_ff];
   assign dq = (diff + (diff[10] ? 11'sd3 : 11'sd0)) >>> 2;
   assign upd_q = avgq_ff[pos_ff] + dq;

   always_comb begin
      count_in = count_ff;
      scan_in = scan_ff;
      sh_in = sh_ff;
      pos_in = pos_ff;
      found_in = found_ff;
      wage_in = wage_ff;
      worst_in = worst_ff;
      removed_in = removed_ff;
      status_in = status_ff;
      if (ctl.load) begin
         scan_in = '0;
         found_in = 1'b0;
         wage_in = '0;
         worst_in = '0;
         removed_in = '0;
         pos_in = count_ff[ptwa_pkg::IDX_W-1:0];
         status_in = ptwa_pkg::ST_DONE;
      end
      if (ctl.scan_start) begin
         scan_in = '0;
      end
      if (ctl.scan_step) begin
         case (req_ff.cmd)
            ptwa_pkg::CMD_BEACON: begin
               if (!found_ff && hit) begin
                  found_in = 1'b1;
                  pos_in = scan_ff;
               end
               if (in_table && (age > wage_ff ||
                   (age == wage_ff && dbm_i < dbm_w))) begin
                  wage_in = age;
                  worst_in = scan_ff;
               end
               scan_in = scan_ff + 1'b1;
            end
            ptwa_pkg::CMD_SWEEP: begin
               if (in_table && expired) begin
                  sh_in = scan_ff;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (ctl.shift_step) begin
         if ({1'b0, sh_ff} + 1'b1 >= count_ff) begin
            count_in = count_ff - 1'b1;
            removed_in = removed_ff + 1'b1;
         end else begin
            sh_in = sh_ff + 1'b1;
         end
      end
      if (ctl.write) begin
         if (found_ff) begin
            status_in = ptwa_pkg::ST_UPDATED;
         end else begin
            status_in = (removed_ff != '0) ? ptwa_pkg::ST_EVICTED : ptwa_pkg::ST_INSERTED;
            pos_in = count_ff[ptwa_pkg::IDX_W-1:0];
            count_in = count_ff + 1'b1;
         end
      end
   end

   assign wpos = found_ff ? pos_ff : count_ff[ptwa_pkg::IDX_W-1:0];
   assign new_hits = found_ff ? ((hits_ff[pos_ff] == 8'hFF) ? 8'hFF : hits_ff[pos_ff] + 8'd1)
                              : 8'd1;
   assign new_qual = !(found_ff && qual_ff[pos_ff]) && new_hits >= hit_threshold;

   always_comb begin
      sts.scan_last = (scan_ff == ptwa_pkg::IDX_W'(ptwa_pkg::TABLE_DEPTH - 1)) ||
                      ({1'b0, scan_ff} + 1'b1 >= count_ff);
      sts.need_shift = 1'b0;
      sts.need_write = 1'b0;
      case (req_ff.cmd)
         ptwa_pkg::CMD_BEACON: begin
            sts.need_write = 1'b1;
            sts.need_shift = !found_ff && !hit &&
                             count_ff == ptwa_pkg::CNT_W'(ptwa_pkg::TABLE_DEPTH);
         end
         ptwa_pkg::CMD_SWEEP: begin
            sts.need_shift = in_table && expired;
            sts.scan_last = !in_table ||
                            (!expired && {1'b0, scan_ff} + 1'b1 >= count_ff);
         end
         default: ;
      endcase
      sts.shift_last = {1'b0, sh_ff} + 1'b1 >= count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (ctl.load) begin
         req_ff <= req_word;
      end
      scan_ff <= scan_in;
      pos_ff <= pos_in;
      found_ff <= found_in;
      wage_ff <= wage_in;
      worst_ff <= worst_in;
      removed_ff <= removed_in;
      status_ff <= status_in;
      if (ctl.scan_step && req_ff.cmd == ptwa_pkg::CMD_BEACON && sts.scan_last &&
          sts.need_shift) begin
         sh_ff <= worst_in;
      end else begin
         sh_ff <= sh_in;
      end
      if (ctl.shift_step && !sts.shift_last) begin
         ids_ff[sh_ff] <= ids_ff[sh_ff + 1'b1];
         seen_ff[sh_ff] <= seen_ff[sh_ff + 1'b1];
         avgq_ff[sh_ff] <= avgq_ff[sh_ff + 1'b1];
         caps_ff[sh_ff] <= caps_ff[sh_ff + 1'b1];
         slot_ff[sh_ff] <= slot_ff[sh_ff + 1'b1];
         hits_ff[sh_ff] <= hits_ff[sh_ff + 1'b1];
         qual_ff[sh_ff] <= qual_ff[sh_ff + 1'b1];
      end
      if (ctl.write) begin
         ids_ff[wpos] <= req_ff.beacon_id;
         seen_ff[wpos] <= req_ff.now_time;
         avgq_ff[wpos] <= found_ff ? upd_q : sig4;
         caps_ff[wpos] <= req_ff.capabilities;
         slot_ff[wpos] <= req_ff.radio_slot;
         hits_ff[wpos] <= new_hits;
         qual_ff[wpos] <= (found_ff && qual_ff[pos_ff]) || new_qual;
         nq_ff <= new_qual;
      end else if (ctl.load) begin
         nq_ff <= 1'b0;
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.occupancy = count_ff;
      rsp_in.removed = removed_ff;
      case (req_ff.cmd)
         ptwa_pkg::CMD_BEACON: begin
            if (req_ff.signal < signal_floor) begin
               rsp_in.status = ptwa_pkg::ST_WEAK;
               rsp_in.removed = '0;
            end else if (req_ff.beacon_id == own_id) begin
               rsp_in.status = ptwa_pkg::ST_OWN;
               rsp_in.removed = '0;
            end else begin
               rsp_in.status = status_ff;
               rsp_in.position = pos_ff;
               rsp_in.newly_qualified = nq_ff;
               rsp_in.avg_signal = ptwa_pkg::quarter_to_dbm(avgq_ff[pos_ff]);
               rsp_in.entry_id = ids_ff[pos_ff];
               rsp_in.entry_caps = caps_ff[pos_ff];
               rsp_in.entry_slot = slot_ff[pos_ff];
               rsp_in.entry_hits = hits_ff[pos_ff];
               rsp_in.entry_qualified = qual_ff[pos_ff];
            end
         end
         ptwa_pkg::CMD_SWEEP: rsp_in.status = ptwa_pkg::ST_DONE;
         ptwa_pkg::CMD_READ: begin
            if ({1'b0, req_ff.entry_index} < count_ff) begin
               rsp_in.status = ptwa_pkg::ST_DONE;
               rsp_in.position = req_ff.entry_index;
               rsp_in.avg_signal =
                  ptwa_pkg::quarter_to_dbm(avgq_ff[req_ff.entry_index]);
               rsp_in.entry_id = ids_ff[req_ff.entry_index];
               rsp_in.entry_caps = caps_ff[req_ff.entry_index];
               rsp_in.entry_slot = slot_ff[req_ff.entry_index];
               rsp_in.entry_hits = hits_ff[req_ff.entry_index];
               rsp_in.entry_qualified = qual_ff[req_ff.entry_index];
            end else begin
               rsp_in.status = ptwa_pkg::ST_BAD;
            end
         end
         default: rsp_in.status = ptwa_pkg::ST_BAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

// ===== src/ptwa_control.sv =====
module ptwa_control (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  ptwa_pkg::req_word_type req_word,
   input  logic [31:0] own_id,
   input  logic signed [7:0] signal_floor,
   output logic rsp_valid,
   input  logic rsp_stall,
   output ptwa_pkg::ctl_type ctl,
   input  ptwa_pkg::sts_type sts
);

   ptwa_pkg::fsm_type state_ff, state_in;
   logic valid_ff, valid_in;
   logic go_ff, go_in;
   logic accept;

   assign req_stall = (state_ff != ptwa_pkg::FSM_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && rsp_stall;
      go_in = go_ff;
      ctl = '0;
      case (state_ff)
         ptwa_pkg::FSM_IDLE: begin
            if (accept) begin
               ctl.load = 1'b1;
               go_in = (req_word.cmd == ptwa_pkg::CMD_SWEEP) ||
                       (req_word.cmd == ptwa_pkg::CMD_BEACON &&
                        !(req_word.signal < signal_floor) &&
                        req_word.beacon_id != own_id);
               state_in = ptwa_pkg::FSM_SCAN;
            end
         end
         ptwa_pkg::FSM_SCAN: begin
            if (!go_ff) begin
               state_in = ptwa_pkg::FSM_RESULT;
            end else begin
               ctl.scan_step = 1'b1;
               if (sts.need_shift && !sts.need_write) begin
                  state_in = ptwa_pkg::FSM_SHIFT;
               end else if (sts.scan_last) begin
                  if (sts.need_shift) begin
                     state_in = ptwa_pkg::FSM_SHIFT;
                  end else if (sts.need_write) begin
                     state_in = ptwa_pkg::FSM_WRITE;
                  end else begin
                     state_in = ptwa_pkg::FSM_RESULT;
                  end
               end
            end
         end
         ptwa_pkg::FSM_SHIFT: begin
            ctl.shift_step = 1'b1;
            if (sts.shift_last) begin
               state_in = sts.need_write ? ptwa_pkg::FSM_WRITE : ptwa_pkg::FSM_SCAN;
            end
         end
         ptwa_pkg::FSM_WRITE: begin
            ctl.write = 1'b1;
            state_in = ptwa_pkg::FSM_RESULT;
         end
         ptwa_pkg::FSM_RESULT: begin
            if (!valid_ff || !rsp_stall) begin
               ctl.result = 1'b1;
               valid_in = 1'b1;
               state_in = ptwa_pkg::FSM_IDLE;
            end
         end
         default: state_in = ptwa_pkg::FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptwa_pkg::FSM_IDLE;
         valid_ff <= 1'b0;
         go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         go_ff <= go_in;
      end
   end

endmodule

// ===== src/peer_table_with_aging_core.sv =====
// Neighbor table of up to eight peers, ordered by arrival, with least recently seen
// eviction and a timeout sweep. A beacon scans the entries one by one, then, when the
// table is full and the peer is new, compacts the table by shifting entries down,
// then writes the entry, then registers the result. A sweep alternates between
// scanning and shifting out each expired entry. A read or a refused beacon skips the
// scan and goes straight to the result. One word is processed at a time; the result
// register lets the next word enter while the last result waits to be taken.
module peer_table_with_aging_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  ptwa_pkg::req_word_type req_word,
   output logic rsp_valid,
   input  logic rsp_stall,
   output ptwa_pkg::rsp_word_type rsp_word,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [3:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   logic [31:0] own_id_ff;
   logic signed [7:0] floor_ff;
   logic [31:0] ttl_ff;
   logic [7:0] thresh_ff;
   logic wr;
   ptwa_pkg::ctl_type ctl;
   ptwa_pkg::sts_type sts;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= '0;
         floor_ff <= -8'sd90;
         ttl_ff <= 32'd30000;
         thresh_ff <= 8'd3;
      end else if (wr) begin
         case (csr_paddr[3:2])
            ptwa_pkg::REG_OWN_ID:    own_id_ff <= csr_pwdata;
            ptwa_pkg::REG_FLOOR:     floor_ff <= csr_pwdata[7:0];
            ptwa_pkg::REG_TTL:       ttl_ff <= csr_pwdata;
            ptwa_pkg::REG_THRESHOLD: thresh_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         ptwa_pkg::REG_OWN_ID:    csr_prdata = own_id_ff;
         ptwa_pkg::REG_FLOOR:     csr_prdata = {{24{floor_ff[7]}}, floor_ff};
         ptwa_pkg::REG_TTL:       csr_prdata = ttl_ff;
         ptwa_pkg::REG_THRESHOLD: csr_prdata = {24'd0, thresh_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   ptwa_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .own_id(own_id_ff), .signal_floor(floor_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .ctl(ctl), .sts(sts)
   );

   ptwa_datapath u_datapath (
      .clock(clock), .reset(reset),
      .ctl(ctl), .sts(sts), .req_word(req_word),
      .own_id(own_id_ff), .signal_floor(floor_ff),
      .time_to_live(ttl_ff), .hit_threshold(thresh_ff),
      .rsp_word(rsp_word)
   );

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   a_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.occupancy <= 4'd8) else $error("occupancy overflow");
   a_rem: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ptwa_pkg::ST_EVICTED |-> rsp_word.removed == 4'd1)
      else $error("eviction count");

endmodule
